@@ sv/dbm_pkg.sv @@
`timescale 1ns / 1ps

package dbm_pkg;

  // Default sizes of the tables
  localparam int NUM_STATES_DEF = 256;
  localparam int NUM_GROUPS_DEF = 256;
  localparam int MAX_IDS_DEF    = 4;
  localparam int ID_BITS_DEF    = 12;

  // Fixed field widths of the request and result ports
  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int STATE_IN_W = 8;
  localparam int GROUP_IN_W = 8;
  localparam int COUNT_IN_W = 3;
  localparam int SLOT_IN_W  = 2;
  localparam int ID_IN_W    = 12;
  localparam int ID_OUT_W   = 12;

  // Entries of a table indexed by one 8-bit field
  localparam int BYTE_TABLE_DEPTH = 1 << BYTE_W;

  // Packet tag width of the report marks, and result queue depth
  localparam int EPOCH_W        = 16;
  localparam int OUT_FIFO_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_GMAP  = 2'd1,
    OP_TRANS = 2'd2,
    OP_FINAL = 2'd3
  } op_t;

endpackage

@@ sv/dbm_ram.sv @@
`timescale 1ns / 1ps

module dbm_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/dfa_byte_matcher_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// in_*     in   in_valid / in_ready    operation, data_byte, last_byte, row_state,
//                                      column_group, next_state, next_valid,
//                                      final_flag, id_count, id_slot, id_value
// out_*    out  out_valid / out_ready  matched_id, last_in_run
// cfg_*    in   cfg_wr_en              cfg_wr_data = start_state
//
// A payload byte does a group map read, then the dependent transition memory read;
// the next byte's reads overlap the transition result. Each reported id takes a
// read on the id memory port, held back while the result queue has no room; a last
// byte whose edge exists adds an accept check, and a closing step when that check
// reports ids. Loads and bytes of a stopped packet do not enter the lookup states.
// After reset the report marks are swept, and again every 2^16-1 packets.
module dfa_byte_matcher_core #(
  parameter int NUM_STATES        = dbm_pkg::NUM_STATES_DEF,
  parameter int NUM_GROUPS        = dbm_pkg::NUM_GROUPS_DEF,
  parameter int MAX_IDS_PER_STATE = dbm_pkg::MAX_IDS_DEF,
  parameter int ID_BITS           = dbm_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dbm_pkg::OP_W-1:0]        in_operation,
  input  logic [dbm_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_last_byte,
  input  logic [dbm_pkg::STATE_IN_W-1:0]  in_row_state,
  input  logic [dbm_pkg::GROUP_IN_W-1:0]  in_column_group,
  input  logic [dbm_pkg::STATE_IN_W-1:0]  in_next_state,
  input  logic                            in_next_valid,
  input  logic                            in_final_flag,
  input  logic [dbm_pkg::COUNT_IN_W-1:0]  in_id_count,
  input  logic [dbm_pkg::SLOT_IN_W-1:0]   in_id_slot,
  input  logic [dbm_pkg::ID_IN_W-1:0]     in_id_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dbm_pkg::ID_OUT_W-1:0]    out_matched_id,
  output logic                            out_last_in_run,
  input  logic                            cfg_wr_en,
  input  logic [dbm_pkg::STATE_IN_W-1:0]  cfg_wr_data
);

  import dbm_pkg::*;

  localparam int SW     = $clog2(NUM_STATES);
  localparam int GW     = $clog2(NUM_GROUPS);
  localparam int CW     = $clog2(MAX_IDS_PER_STATE + 1);
  localparam int TDEPTH = NUM_STATES * NUM_GROUPS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int IDEPTH = NUM_STATES * MAX_IDS_PER_STATE;
  localparam int IAW    = $clog2(IDEPTH);
  localparam int FPW    = $clog2(OUT_FIFO_DEPTH);
  localparam int FCW    = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int FLW    = FCW + 1;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [SW-1:0]      LAST_ROW  = SW'(NUM_STATES - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_RUN,
    S_GRP,
    S_EMIT,
    S_TRN,
    S_CHK,
    S_FIN
  } seq_state_t;

  // Wrap tables for 8-bit state and group fields
  logic [SW-1:0] state_wrap [BYTE_TABLE_DEPTH];
  logic [GW-1:0] group_wrap [BYTE_TABLE_DEPTH];

  for (genvar gi = 0; gi < BYTE_TABLE_DEPTH; gi++) begin : g_wrap
    assign state_wrap[gi] = SW'(gi % NUM_STATES);
    assign group_wrap[gi] = GW'(gi % NUM_GROUPS);
  end

  // Input register
  logic                   buf_valid_r, buf_valid_nxt;
  logic [OP_W-1:0]        buf_op_r;
  logic [BYTE_W-1:0]      buf_byte_r;
  logic                   buf_last_r;
  logic [STATE_IN_W-1:0]  buf_row_r;
  logic [GROUP_IN_W-1:0]  buf_col_r;
  logic [STATE_IN_W-1:0]  buf_next_r;
  logic                   buf_nvalid_r;
  logic                   buf_final_r;
  logic [COUNT_IN_W-1:0]  buf_count_r;
  logic [SLOT_IN_W-1:0]   buf_slot_r;
  logic [ID_IN_W-1:0]     buf_id_r;
  logic                   consume;
  logic                   in_take;

  // Sequencer and packet state
  seq_state_t             seq_r, seq_nxt;
  logic [STATE_IN_W-1:0]  start_state_r;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   pkt_r, pkt_nxt;
  logic [EPOCH_W-1:0]     epoch_r, epoch_nxt;
  logic                   last_r, last_nxt;
  logic [SW-1:0]          clr_idx_r, clr_idx_nxt;
  logic                   emit_run2_r, emit_run2_nxt;
  logic [SW-1:0]          emit_st_r, emit_st_nxt;
  logic [CW-1:0]          emit_cnt_r, emit_cnt_nxt;
  logic [CW-1:0]          emit_idx_r, emit_idx_nxt;
  logic                   close_r, close_nxt;
  logic                   id_inflight_r;
  logic                   rep_fwd_r, rep_fwd_nxt;
  logic [EPOCH_W-1:0]     rep_fwd_tag_r;

  logic                   step_done;
  logic                   issue_en;
  logic [SW-1:0]          cur_now;
  logic                   stopped_now;
  logic                   pkt_now;
  logic [SW-1:0]          cur_i;
  logic                   stop_i;
  logic [CW-1:0]          cnt_sat;

  // Memory ports
  logic                   gm_we, gm_re;
  logic [BYTE_W-1:0]      gm_waddr, gm_raddr;
  logic [GW-1:0]          gm_wdata, gm_rdata;

  logic                   trans_we, trans_re;
  logic [TAW-1:0]         trans_waddr, trans_raddr;
  logic [SW:0]            trans_wdata, trans_rdata;

  logic                   acc_we, acc_re;
  logic [SW-1:0]          acc_waddr, acc_raddr;
  logic [CW:0]            acc_wdata, acc_rdata;

  logic                   id_we, id_re;
  logic [IAW-1:0]         id_waddr, id_raddr;
  logic [ID_BITS-1:0]     id_wdata, id_rdata;

  logic                   rep_we, rep_re;
  logic [SW-1:0]          rep_waddr, rep_raddr;
  logic [EPOCH_W-1:0]     rep_wdata, rep_rdata;

  logic                   acc_mark;
  logic [CW-1:0]          acc_cnt;
  logic [EPOCH_W-1:0]     rep_tag;
  logic                   reported;
  logic                   edge_ok;
  logic [SW-1:0]          edge_st;

  // Result holding and queue
  logic                   pend_valid_r, pend_valid_nxt;
  logic [ID_OUT_W-1:0]    pend_id_r, pend_id_nxt;
  logic                   fifo_push, fifo_pop, push_last;
  logic [ID_OUT_W-1:0]    fifo_id_r   [OUT_FIFO_DEPTH];
  logic                   fifo_last_r [OUT_FIFO_DEPTH];
  logic [FPW-1:0]         fifo_wp_r, fifo_rp_r;
  logic [FCW-1:0]         fifo_cnt_r;
  logic [FLW-1:0]         fifo_load;
  logic                   credit_ok;

  // Tables
  dbm_ram #(.WIDTH(GW), .DEPTH(BYTE_TABLE_DEPTH)) u_group_map (
    .clk(clk), .wr_en(gm_we), .wr_addr(gm_waddr), .wr_data(gm_wdata),
    .rd_en(gm_re), .rd_addr(gm_raddr), .rd_data(gm_rdata)
  );

  dbm_ram #(.WIDTH(SW + 1), .DEPTH(TDEPTH)) u_trans (
    .clk(clk), .wr_en(trans_we), .wr_addr(trans_waddr), .wr_data(trans_wdata),
    .rd_en(trans_re), .rd_addr(trans_raddr), .rd_data(trans_rdata)
  );

  dbm_ram #(.WIDTH(CW + 1), .DEPTH(NUM_STATES)) u_accept (
    .clk(clk), .wr_en(acc_we), .wr_addr(acc_waddr), .wr_data(acc_wdata),
    .rd_en(acc_re), .rd_addr(acc_raddr), .rd_data(acc_rdata)
  );

  dbm_ram #(.WIDTH(ID_BITS), .DEPTH(IDEPTH)) u_ids (
    .clk(clk), .wr_en(id_we), .wr_addr(id_waddr), .wr_data(id_wdata),
    .rd_en(id_re), .rd_addr(id_raddr), .rd_data(id_rdata)
  );

  dbm_ram #(.WIDTH(EPOCH_W), .DEPTH(NUM_STATES)) u_report (
    .clk(clk), .wr_en(rep_we), .wr_addr(rep_waddr), .wr_data(rep_wdata),
    .rd_en(rep_re), .rd_addr(rep_raddr), .rd_data(rep_rdata)
  );

  // Decode read data
  assign acc_mark = acc_rdata[CW];
  assign acc_cnt  = acc_rdata[CW-1:0];
  assign rep_tag  = rep_fwd_r ? rep_fwd_tag_r : rep_rdata;
  assign reported = (rep_tag == epoch_r);
  assign edge_ok  = trans_rdata[SW];
  assign edge_st  = trans_rdata[SW-1:0];

  // Issue an id read only when its result is sure to find room in the queue
  assign fifo_load = FLW'(fifo_cnt_r) + FLW'(pend_valid_r) + FLW'(id_inflight_r);
  assign credit_ok = fifo_load < FLW'(OUT_FIFO_DEPTH);

  assign cnt_sat = (int'(buf_count_r) > MAX_IDS_PER_STATE) ? CW'(MAX_IDS_PER_STATE)
                                                            : CW'(buf_count_r);

  // Sequencer
  always_comb begin
    seq_nxt       = seq_r;
    cur_nxt       = cur_r;
    stopped_nxt   = stopped_r;
    pkt_nxt       = pkt_r;
    epoch_nxt     = epoch_r;
    last_nxt      = last_r;
    clr_idx_nxt   = clr_idx_r;
    emit_run2_nxt = emit_run2_r;
    emit_st_nxt   = emit_st_r;
    emit_cnt_nxt  = emit_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    close_nxt     = 1'b0;
    step_done     = 1'b0;
    consume       = 1'b0;
    cur_now       = cur_r;
    stopped_now   = stopped_r;
    cur_i         = cur_r;
    stop_i        = stopped_r;

    gm_we = 1'b0; gm_waddr = '0; gm_wdata = '0;
    gm_re = 1'b0; gm_raddr = '0;
    trans_we = 1'b0; trans_waddr = '0; trans_wdata = '0;
    trans_re = 1'b0; trans_raddr = '0;
    acc_we = 1'b0; acc_waddr = '0; acc_wdata = '0;
    acc_re = 1'b0; acc_raddr = '0;
    id_we = 1'b0; id_waddr = '0; id_wdata = '0;
    id_re = 1'b0; id_raddr = '0;
    rep_we = 1'b0; rep_waddr = '0; rep_wdata = '0;
    rep_re = 1'b0; rep_raddr = '0;

    unique case (seq_r)
      S_CLR: begin
        // Sweep the report marks to the never-reported tag
        rep_we      = 1'b1;
        rep_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + SW'(1);
        if (clr_idx_r == LAST_ROW) begin
          clr_idx_nxt = '0;
          epoch_nxt   = '0;
          seq_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        seq_nxt = S_RUN;
      end
      S_GRP: begin
        // Look up the edge; report the current state if it accepts
        trans_re    = 1'b1;
        trans_raddr = TAW'(cur_r) * TAW'(NUM_GROUPS) + TAW'(gm_rdata);
        if (acc_mark && !reported) begin
          rep_we    = 1'b1;
          rep_waddr = cur_r;
          rep_wdata = epoch_r;
        end
        if (acc_mark && !reported && acc_cnt != '0) begin
          seq_nxt       = S_EMIT;
          emit_run2_nxt = 1'b0;
          emit_st_nxt   = cur_r;
          emit_cnt_nxt  = acc_cnt;
          emit_idx_nxt  = '0;
        end else begin
          seq_nxt = S_TRN;
        end
      end
      S_EMIT: begin
        // Read one id per cycle while the result queue has room
        if (credit_ok) begin
          id_re        = 1'b1;
          id_raddr     = IAW'(emit_st_r) * IAW'(MAX_IDS_PER_STATE) + IAW'(emit_idx_r);
          emit_idx_nxt = emit_idx_r + CW'(1);
          if (emit_idx_r == emit_cnt_r - CW'(1)) begin
            if (emit_run2_r) begin
              seq_nxt = S_FIN;
            end else begin
              seq_nxt = S_TRN;
            end
          end
        end
      end
      S_TRN: begin
        // Take the edge, or stop the packet on a missing one
        if (!edge_ok) begin
          stopped_now = 1'b1;
          step_done   = 1'b1;
        end else begin
          cur_now = edge_st;
          if (last_r) begin
            acc_re    = 1'b1;
            acc_raddr = edge_st;
            rep_re    = 1'b1;
            rep_raddr = edge_st;
            seq_nxt   = S_CHK;
          end else begin
            step_done = 1'b1;
          end
        end
      end
      S_CHK: begin
        // Accept check of the state reached on the last byte
        if (acc_mark && !reported) begin
          rep_we    = 1'b1;
          rep_waddr = cur_r;
          rep_wdata = epoch_r;
        end
        if (acc_mark && !reported && acc_cnt != '0) begin
          seq_nxt       = S_EMIT;
          emit_run2_nxt = 1'b1;
          emit_st_nxt   = cur_r;
          emit_cnt_nxt  = acc_cnt;
          emit_idx_nxt  = '0;
        end else begin
          step_done = 1'b1;
        end
      end
      S_FIN: begin
        // Close the step once the final id read has returned
        step_done = 1'b1;
      end
      default: begin
        seq_nxt = S_CLR;
      end
    endcase

    // Close the step and fold its effect into the packet state
    pkt_now     = pkt_r | (step_done & last_r);
    cur_nxt     = cur_now;
    stopped_nxt = stopped_now;
    pkt_nxt     = pkt_now;
    if (step_done) begin
      seq_nxt   = S_RUN;
      close_nxt = 1'b1;
    end

    // Start the next request
    issue_en = (seq_r == S_RUN) || step_done;
    if (issue_en && buf_valid_r) begin
      unique case (op_t'(buf_op_r))
        OP_GMAP: begin
          gm_we    = 1'b1;
          gm_waddr = buf_byte_r;
          gm_wdata = group_wrap[buf_col_r];
          consume  = 1'b1;
        end
        OP_TRANS: begin
          trans_we    = 1'b1;
          trans_waddr = TAW'(state_wrap[buf_row_r]) * TAW'(NUM_GROUPS)
                      + TAW'(group_wrap[buf_col_r]);
          trans_wdata = {buf_nvalid_r, state_wrap[buf_next_r]};
          consume     = 1'b1;
        end
        OP_FINAL: begin
          acc_we    = 1'b1;
          acc_waddr = state_wrap[buf_row_r];
          acc_wdata = {buf_final_r, cnt_sat};
          if (int'(buf_slot_r) < MAX_IDS_PER_STATE) begin
            id_we    = 1'b1;
            id_waddr = IAW'(state_wrap[buf_row_r]) * IAW'(MAX_IDS_PER_STATE)
                     + IAW'(buf_slot_r);
            id_wdata = ID_BITS'(buf_id_r);
          end
          consume = 1'b1;
        end
        OP_BYTE: begin
          if (pkt_now && epoch_r == EPOCH_MAX) begin
            // Packet tag exhausted: sweep the marks first, hold the request
            seq_nxt = S_CLR;
          end else begin
            consume = 1'b1;
            cur_i   = pkt_now ? state_wrap[start_state_r] : cur_now;
            stop_i  = stopped_now & ~pkt_now;
            if (pkt_now) begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
              pkt_nxt   = 1'b0;
            end
            cur_nxt     = cur_i;
            stopped_nxt = stop_i;
            if (stop_i) begin
              // Drop the byte; a last byte still ends the packet
              if (buf_last_r) begin
                pkt_nxt = 1'b1;
              end
            end else begin
              gm_re     = 1'b1;
              gm_raddr  = buf_byte_r;
              acc_re    = 1'b1;
              acc_raddr = cur_i;
              rep_re    = 1'b1;
              rep_raddr = cur_i;
              last_nxt  = buf_last_r;
              seq_nxt   = S_GRP;
            end
          end
        end
        default: begin
          consume = 1'b0;
        end
      endcase
    end

    // Forward a report mark written while the same entry is read
    rep_fwd_nxt = rep_we && rep_re && (rep_waddr == rep_raddr);
  end

  // Input register handshake
  assign in_ready = !buf_valid_r || consume;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    if (in_take) begin
      buf_valid_nxt = 1'b1;
    end else if (consume) begin
      buf_valid_nxt = 1'b0;
    end
  end

  // Hold back the newest id so the run's final one can be flagged
  always_comb begin
    fifo_push      = 1'b0;
    push_last      = 1'b0;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    if (id_inflight_r) begin
      fifo_push      = pend_valid_r;
      pend_valid_nxt = 1'b1;
      pend_id_nxt    = ID_OUT_W'(id_rdata);
    end else if (close_r) begin
      fifo_push      = pend_valid_r;
      push_last      = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  // Result queue
  assign out_valid       = (fifo_cnt_r != '0);
  assign out_matched_id  = fifo_id_r[fifo_rp_r];
  assign out_last_in_run = fifo_last_r[fifo_rp_r];
  assign fifo_pop        = out_valid && out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= S_CLR;
      buf_valid_r   <= 1'b0;
      start_state_r <= '0;
      cur_r         <= '0;
      stopped_r     <= 1'b0;
      pkt_r         <= 1'b1;
      epoch_r       <= '0;
      last_r        <= 1'b0;
      clr_idx_r     <= '0;
      emit_run2_r   <= 1'b0;
      emit_cnt_r    <= '0;
      emit_idx_r    <= '0;
      close_r       <= 1'b0;
      id_inflight_r <= 1'b0;
      rep_fwd_r     <= 1'b0;
      pend_valid_r  <= 1'b0;
      fifo_wp_r     <= '0;
      fifo_rp_r     <= '0;
      fifo_cnt_r    <= '0;
    end else begin
      seq_r         <= seq_nxt;
      buf_valid_r   <= buf_valid_nxt;
      if (cfg_wr_en) begin
        start_state_r <= cfg_wr_data;
      end
      cur_r         <= cur_nxt;
      stopped_r     <= stopped_nxt;
      pkt_r         <= pkt_nxt;
      epoch_r       <= epoch_nxt;
      last_r        <= last_nxt;
      clr_idx_r     <= clr_idx_nxt;
      emit_run2_r   <= emit_run2_nxt;
      emit_cnt_r    <= emit_cnt_nxt;
      emit_idx_r    <= emit_idx_nxt;
      close_r       <= close_nxt;
      id_inflight_r <= id_re;
      rep_fwd_r     <= rep_fwd_nxt;
      pend_valid_r  <= pend_valid_nxt;
      if (fifo_push) begin
        fifo_wp_r <= fifo_wp_r + FPW'(1);
      end
      if (fifo_pop) begin
        fifo_rp_r <= fifo_rp_r + FPW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FCW'(fifo_push) - FCW'(fifo_pop);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_op_r     <= in_operation;
      buf_byte_r   <= in_data_byte;
      buf_last_r   <= in_last_byte;
      buf_row_r    <= in_row_state;
      buf_col_r    <= in_column_group;
      buf_next_r   <= in_next_state;
      buf_nvalid_r <= in_next_valid;
      buf_final_r  <= in_final_flag;
      buf_count_r  <= in_id_count;
      buf_slot_r   <= in_id_slot;
      buf_id_r     <= in_id_value;
    end
    emit_st_r     <= emit_st_nxt;
    rep_fwd_tag_r <= rep_wdata;
    pend_id_r     <= pend_id_nxt;
    if (fifo_push) begin
      fifo_id_r[fifo_wp_r]   <= pend_id_r;
      fifo_last_r[fifo_wp_r] <= push_last;
    end
  end

  // The id credit keeps the result queue from overflowing
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_push && !fifo_pop && fifo_cnt_r == FCW'(OUT_FIFO_DEPTH)))
    else $error("result queue overflow");

  // A run closes only after its last id read has returned
  a_close_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    close_r |-> !id_inflight_r)
    else $error("run closed with an id read in flight");

  // No request is taken while the report marks are swept
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_CLR) |-> !consume)
    else $error("request taken during mark sweep");

  // A transition lookup never runs for a stopped packet
  a_grp_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_GRP) |-> !stopped_r)
    else $error("lookup started on a stopped packet");

endmodule
